[hdl/dsp_pkg.sv]
// Shared constants, types and helpers for the shortest-path engine.
package dsp_pkg;

  localparam int MAX_NODES = 16;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int ADDR_W    = 2 * NODE_W;
  localparam int DEPTH     = MAX_NODES * MAX_NODES;
  localparam int WEIGHT_W  = 8;
  localparam int DIST_W    = 12;
  localparam int NC_W      = 5;
  localparam int PORT_W    = 4;
  localparam int CIDX_W    = 2;
  localparam int CDATA_W   = 5;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_RUN   = 2'd2;

  localparam logic [CIDX_W-1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_SOURCE     = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_TARGET     = 2'd2;

  // Control word from the sequencer to the weight store.
  typedef struct packed {
    logic                clear;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [WEIGHT_W-1:0] wr_data;
    logic [ADDR_W-1:0]   rd_addr;
  } wm_ctrl_t;

  // The matrix is symmetric, so each undirected edge lives at one address.
  function automatic logic [ADDR_W-1:0] canon_addr(input logic [NODE_W-1:0] a,
                                                   input logic [NODE_W-1:0] b);
    logic [ADDR_W-1:0] r;
    if (a < b) r = {a, b};
    else       r = {b, a};
    return r;
  endfunction

endpackage

[hdl/dsp_weight_store.sv]
// Edge weight matrix: one write port, one registered read port, per-entry valid bits.
module dsp_weight_store (
  input  logic                         clk,
  input  logic                         rst,
  input  dsp_pkg::wm_ctrl_t            ctrl,
  output logic [dsp_pkg::WEIGHT_W-1:0] rd_weight
);
  import dsp_pkg::*;

  logic [WEIGHT_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]    vld;
  logic [WEIGHT_W-1:0] rd_data;
  logic                rd_vld;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[ctrl.wr_addr] <= ctrl.wr_data;
    end
    rd_data <= mem[ctrl.rd_addr];
  end

  // An entry that was never written since the last clear reads as no edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= vld[ctrl.rd_addr];
      if (ctrl.clear) begin
        vld <= '0;
      end else if (ctrl.wr_en) begin
        vld[ctrl.wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_weight = rd_vld ? rd_data : '0;

endmodule

[hdl/dijkstra_shortest_path.sv]
// Top level of the dense shortest-path engine: command port, sequencer and result output.
//
// Busy stays low after a clear and is high for one cycle after an add. A run first searches
// from the source over the n active nodes, then walks back from the target node by node
// along the predecessors, then sends the edges of the path.
// The search pace is set by the single read port of the weight matrix: one matrix entry is
// read and relaxed per cycle, and the next node to settle is picked during the same pass.
// Results come one per cycle on result_strobe and cannot be held off by the receiver;
// last marks the final word of a run. Config writes are always accepted (cfg_ready is high)
// and must only be issued while busy is low.
module dijkstra_shortest_path (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  operation,
  input  logic [dsp_pkg::PORT_W-1:0]  node_a,
  input  logic [dsp_pkg::PORT_W-1:0]  node_b,
  input  logic [dsp_pkg::WEIGHT_W-1:0] weight,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [dsp_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [dsp_pkg::CDATA_W-1:0] cfg_data,
  output logic                        result_strobe,
  output logic [dsp_pkg::PORT_W-1:0]  edge_from,
  output logic [dsp_pkg::PORT_W-1:0]  edge_to,
  output logic                        edge_valid,
  output logic                        reachable,
  output logic [dsp_pkg::DIST_W-1:0]  target_distance,
  output logic                        last
);
  import dsp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ADD_CHK, ST_INIT, ST_RELAX, ST_WALK_INIT, ST_WALK, ST_EMIT_LOAD, ST_EMIT
  } state_t;

  state_t state;

  logic [NC_W-1:0]   cfg_nodes;
  logic [PORT_W-1:0] cfg_src;
  logic [PORT_W-1:0] cfg_dst;

  logic [CNT_W-1:0]  n_act;
  logic [NODE_W-1:0] src_c;
  logic [NODE_W-1:0] dst_c;

  logic [ADDR_W-1:0]   add_addr;
  logic [WEIGHT_W-1:0] add_w;
  logic                add_ok;

  logic [NODE_W-1:0]    cur;
  logic [DIST_W-1:0]    best;
  logic [MAX_NODES-1:0] settled;
  logic [MAX_NODES-1:0] finite;
  logic [MAX_NODES-1:0] pvalid;
  logic [DIST_W-1:0]    node_dist [MAX_NODES];
  logic [NODE_W-1:0]    pred [MAX_NODES];
  logic [CNT_W-1:0]     idx;
  logic [NODE_W-1:0]    proc_idx;
  logic                 nxt_found;
  logic [NODE_W-1:0]    nxt_cur;
  logic [DIST_W-1:0]    nxt_best;

  logic [NODE_W-1:0] path_buf [MAX_NODES];
  logic [CNT_W-1:0]  cnt;
  logic [NODE_W-1:0] walk_node;
  logic [NODE_W-1:0] prev;
  logic [CNT_W-1:0]  ei;
  logic              reach;
  logic [DIST_W-1:0] tdist;

  wm_ctrl_t            wm_ctrl;
  logic [WEIGHT_W-1:0] rd_weight;

  logic                accept;
  logic [NODE_W-1:0]   dist_raddr;
  logic [DIST_W-1:0]   dj;
  logic [DIST_W:0]     sum;
  logic                upd;
  logic [DIST_W-1:0]   nd;
  logic                nf;
  logic                cand;
  logic                fnd_new;
  logic [NODE_W-1:0]   cur_new;
  logic [DIST_W-1:0]   best_new;
  logic [NODE_W-1:0]   buf_raddr;
  logic [NODE_W-1:0]   buf_rd;
  logic [NODE_W-1:0]   old_pred;

  dsp_weight_store u_weights (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (wm_ctrl),
    .rd_weight (rd_weight)
  );

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_comb begin
    if (cfg_nodes == '0) begin
      n_act = CNT_W'(1);
    end else if (int'(cfg_nodes) > MAX_NODES) begin
      n_act = CNT_W'(MAX_NODES);
    end else begin
      n_act = CNT_W'(cfg_nodes);
    end
    src_c = (CNT_W'(cfg_src) < n_act) ? NODE_W'(cfg_src) : NODE_W'(n_act - 1'b1);
    dst_c = (CNT_W'(cfg_dst) < n_act) ? NODE_W'(cfg_dst) : NODE_W'(n_act - 1'b1);
  end

  // Weight store port use.
  always_comb begin
    wm_ctrl.clear   = accept && (operation == OP_CLEAR);
    wm_ctrl.wr_en   = (state == ST_ADD_CHK) && add_ok &&
                      ((rd_weight == '0) || (add_w < rd_weight));
    wm_ctrl.wr_addr = add_addr;
    wm_ctrl.wr_data = add_w;
    if (state == ST_RELAX) begin
      wm_ctrl.rd_addr = canon_addr(cur, idx[NODE_W-1:0]);
    end else begin
      wm_ctrl.rd_addr = canon_addr(NODE_W'(node_a), NODE_W'(node_b));
    end
  end

  // Relaxation of one neighbor and the running pick of the next node to settle.
  always_comb begin
    dist_raddr = (state == ST_RELAX) ? proc_idx : dst_c;
    dj   = node_dist[dist_raddr];
    sum  = {1'b0, best} + (DIST_W + 1)'(rd_weight);
    upd  = (rd_weight != '0) && !settled[proc_idx] &&
           (!finite[proc_idx] || (sum < {1'b0, dj}));
    nd   = upd ? sum[DIST_W-1:0] : dj;
    nf   = finite[proc_idx] || upd;
    cand = (idx != '0) && !settled[proc_idx] && nf && (!nxt_found || (nd < nxt_best));
    fnd_new  = nxt_found || cand;
    cur_new  = cand ? proc_idx : nxt_cur;
    best_new = cand ? nd : nxt_best;
    if (state == ST_EMIT_LOAD) begin
      buf_raddr = NODE_W'(cnt - 1'b1);
    end else begin
      buf_raddr = NODE_W'(ei - 1'b1);
    end
    buf_rd   = path_buf[buf_raddr];
    old_pred = pred[walk_node];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cfg_nodes     <= NC_W'(8);
      cfg_src       <= '0;
      cfg_dst       <= '0;
      settled       <= '0;
      finite        <= '0;
      pvalid        <= '0;
      nxt_found     <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_NODE_COUNT: cfg_nodes <= cfg_data;
          CFG_SOURCE:     cfg_src   <= PORT_W'(cfg_data);
          CFG_TARGET:     cfg_dst   <= PORT_W'(cfg_data);
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            add_addr <= canon_addr(NODE_W'(node_a), NODE_W'(node_b));
            add_w    <= weight;
            add_ok   <= (CNT_W'(node_a) < n_act) && (CNT_W'(node_b) < n_act) &&
                        (node_a != node_b) && (weight != '0);
            case (operation)
              OP_ADD:  state <= ST_ADD_CHK;
              OP_RUN:  state <= ST_INIT;
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_ADD_CHK: begin
          state <= ST_IDLE;
        end
        ST_INIT: begin
          // Only the source starts out finite, and it is settled before the first pass.
          finite            <= MAX_NODES'(1) << src_c;
          settled           <= MAX_NODES'(1) << src_c;
          pvalid            <= '0;
          node_dist[src_c]  <= '0;
          cur               <= src_c;
          best              <= '0;
          idx               <= '0;
          nxt_found         <= 1'b0;
          state             <= ST_RELAX;
        end
        ST_RELAX: begin
          // Read of entry idx is issued now; entry proc_idx is processed from last read.
          proc_idx <= idx[NODE_W-1:0];
          if ((idx != '0) && upd) begin
            node_dist[proc_idx] <= nd;
            pred[proc_idx]      <= cur;
            finite[proc_idx]    <= 1'b1;
            pvalid[proc_idx]    <= 1'b1;
          end
          if (idx == n_act) begin
            idx       <= '0;
            nxt_found <= 1'b0;
            if (fnd_new) begin
              cur               <= cur_new;
              best              <= best_new;
              settled[cur_new]  <= 1'b1;
            end else begin
              state <= ST_WALK_INIT;
            end
          end else begin
            idx       <= idx + 1'b1;
            nxt_found <= fnd_new;
            nxt_cur   <= cur_new;
            nxt_best  <= best_new;
          end
        end
        ST_WALK_INIT: begin
          reach       <= finite[dst_c];
          tdist       <= finite[dst_c] ? dj : '0;
          path_buf[0] <= dst_c;
          walk_node   <= dst_c;
          cnt         <= finite[dst_c] ? CNT_W'(1) : '0;
          state       <= ST_WALK;
        end
        ST_WALK: begin
          if (pvalid[walk_node] && (cnt < n_act)) begin
            path_buf[cnt[NODE_W-1:0]] <= old_pred;
            walk_node                 <= old_pred;
            cnt                       <= cnt + 1'b1;
          end else begin
            state <= ST_EMIT_LOAD;
          end
        end
        ST_EMIT_LOAD: begin
          if (cnt < CNT_W'(2)) begin
            // Empty path: one word with no edge.
            result_strobe   <= 1'b1;
            edge_from       <= '0;
            edge_to         <= '0;
            edge_valid      <= 1'b0;
            reachable       <= reach;
            target_distance <= tdist;
            last            <= 1'b1;
            state           <= ST_IDLE;
          end else begin
            prev  <= buf_rd;
            ei    <= cnt - 1'b1;
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          result_strobe   <= 1'b1;
          edge_from       <= PORT_W'(prev);
          edge_to         <= PORT_W'(buf_rd);
          edge_valid      <= 1'b1;
          reachable       <= reach;
          target_distance <= tdist;
          last            <= (ei == CNT_W'(1));
          prev            <= buf_rd;
          ei              <= ei - 1'b1;
          if (ei == CNT_W'(1)) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_run_goes_busy: assert property (@(posedge clk) disable iff (rst)
    accept && (operation == OP_RUN) |=> busy)
    else $error("run command did not start the sequencer");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    result_strobe && last |=> !result_strobe)
    else $error("result word after the last word of a run");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !edge_valid |-> last)
    else $error("word without an edge that is not the last");

  a_settled_finite: assert property (@(posedge clk) disable iff (rst)
    (settled & ~finite) == '0)
    else $error("settled node without a finite distance");

endmodule
